>>> sv/dgn_pkg.sv
// Shared constants and types for the DEM gradient core.
// Register index codes, field widths, reset values and fixed-point shifts.
// No dependencies.
package dgn_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int COLS_CFG_W = 13;
	localparam int ROWS_W     = 16;
	localparam int MARKER_W   = 32;
	localparam int INV_W      = 32;
	localparam int GRAD_W     = 32;

	// Q24.8 samples: fractional bits of an elevation
	localparam int FRAC_BITS = 8;

	localparam logic [COLS_CFG_W-1:0] COLS_RESET   = 13'd4096;
	localparam logic [ROWS_W-1:0]     ROWS_RESET   = 16'd4096;
	localparam logic [MARKER_W-1:0]   MARKER_RESET = 32'hFFFF_D8F1; // -9999
	localparam logic [INV_W-1:0]      INV_RESET    = 32'h0001_0000; // 1.0 in Q16.16

	localparam logic [GRAD_W-1:0] GRAD_MAX_POS = 32'h7FFF_FFFF;
	localparam logic [GRAD_W-1:0] GRAD_MIN_NEG = 32'h8000_0000;
	localparam logic [GRAD_W-1:0] GRAD_ONE_LSB = 32'h0000_0001;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_COLUMNS  = 3'd0,
		CFG_GRID_ROWS     = 3'd1,
		CFG_NODATA_MARKER = 3'd2,
		CFG_INV_SPACING_X = 3'd3,
		CFG_INV_SPACING_Y = 3'd4
	} cfg_idx_t;

endpackage

>>> sv/dem_gradient_nodata_core.sv
// Streaming 3x3 central-difference gradient of a raster grid with nodata handling.
// Two line buffers, five pipeline stages; a single module.
// Depends on dgn_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | sink      | in_valid / in_ready  | elevation
//  out     | source    | out_valid / out_ready| gradient_x, gradient_y, cell_missing,
//          |           |                      | last_of_run, end_of_frame
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word per clock in and out unless out_ready stalls. A result leaves once the
// word in the row below it is accepted, via line buffer read, operand select, two
// partial products, product sum, then round and saturate into the output register.
// The line buffers have one write and one registered read port each, all used at
// the accept edge; the right-hand neighbor is fetched one column ahead.
// Stalls ripple back stage by stage, so bubbles are squeezed out before in_ready drops.
// Reset clears control and configuration only; buffer contents stay undefined.
module dem_gradient_nodata_core
	import dgn_pkg::*;
#(
	parameter int MAX_COLUMNS = 4096,
	parameter int ELEV_BITS   = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [ELEV_BITS-1:0] elevation,

	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [GRAD_W-1:0]    gradient_x,
	output logic signed [GRAD_W-1:0]    gradient_y,
	output logic                        cell_missing,
	output logic                        last_of_run,
	output logic                        end_of_frame,

	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	localparam int CI_W   = $clog2(MAX_COLUMNS);
	localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
	localparam int MAG_W  = ELEV_BITS + 1;
	localparam int LO_W   = MAG_W / 2;
	localparam int HI_W   = MAG_W - LO_W;
	localparam int P_W    = MAG_W + INV_W;
	localparam int Q_W    = P_W - FRAC_BITS + 1;
	localparam int ND_W   = ((ELEV_BITS > MARKER_W) ? ELEV_BITS : MARKER_W) + 1;

	// ------------------------------------------------------------------ config
	logic [COLS_CFG_W-1:0]      grid_columns_q;
	logic [ROWS_W-1:0]          grid_rows_q;
	logic signed [MARKER_W-1:0] marker_q;
	logic [INV_W-1:0]           inv_q [2];
	logic                       cfg_wr;
	logic                       restart;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		restart = 1'b0;
		if (cfg_wr) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GRID_COLUMNS, CFG_GRID_ROWS: restart = 1'b1;
				default:                         restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= COLS_RESET;
			grid_rows_q    <= ROWS_RESET;
			marker_q       <= MARKER_RESET;
			inv_q[0]       <= INV_RESET;
			inv_q[1]       <= INV_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GRID_COLUMNS:  grid_columns_q <= cfg_data[COLS_CFG_W-1:0];
				CFG_GRID_ROWS:     grid_rows_q    <= cfg_data[ROWS_W-1:0];
				CFG_NODATA_MARKER: marker_q       <= cfg_data[MARKER_W-1:0];
				CFG_INV_SPACING_X: inv_q[0]       <= cfg_data[INV_W-1:0];
				CFG_INV_SPACING_Y: inv_q[1]       <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [COLS_W-1:0] eff_cols;
	logic [ROWS_W-1:0] eff_rows;

	always_comb begin
		if (grid_columns_q == '0)
			eff_cols = COLS_W'(1);
		else if (int'(grid_columns_q) > MAX_COLUMNS)
			eff_cols = COLS_W'(MAX_COLUMNS);
		else
			eff_cols = COLS_W'(grid_columns_q);
		eff_rows = (grid_rows_q == '0) ? ROWS_W'(1) : grid_rows_q;
	end

	// ------------------------------------------------------------------ pipeline control
	logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
	logic en1, en2, en3, en4;
	logic in_acc;

	assign en4      = !out_valid_q || out_ready;
	assign en3      = !v4_q || en4;
	assign en2      = !v3_q || en3;
	assign en1      = !v2_q || en2;
	assign in_ready = !v1_q || en1;
	assign in_acc   = in_valid && in_ready;

	// ------------------------------------------------------------------ raster position
	logic [CI_W-1:0]   col_q;
	logic [ROWS_W-1:0] row_q;
	logic              frame_done_q;
	logic [CI_W-1:0]   col;
	logic [COLS_W-1:0] col_next;
	logic              has_right;
	logic [CI_W-1:0]   pf_addr;
	logic [ROWS_W:0]   row_next;
	logic              flush;
	logic              produce;

	always_comb begin
		col = col_q;
		if (COLS_W'(col_q) >= eff_cols)
			col = CI_W'(eff_cols - COLS_W'(1));
		col_next  = COLS_W'(col) + COLS_W'(1);
		has_right = col_next < eff_cols;
		pf_addr   = has_right ? CI_W'(col_next) : '0;
		row_next  = {1'b0, row_q} + (ROWS_W + 1)'(1);
		flush     = (row_q == '0);
		produce   = !flush || frame_done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			frame_done_q <= 1'b0;
		end else if (restart) begin
			col_q        <= '0;
			row_q        <= '0;
			frame_done_q <= 1'b0;
		end else if (in_acc) begin
			if (has_right) begin
				col_q <= CI_W'(col_next);
			end else begin
				col_q <= '0;
				if (row_next >= {1'b0, eff_rows}) begin
					row_q        <= '0;
					frame_done_q <= 1'b1;
				end else begin
					row_q <= row_next[ROWS_W-1:0];
				end
			end
		end
	end

	// ------------------------------------------------------------------ line buffers
	logic signed [ELEV_BITS-1:0] line_current [MAX_COLUMNS];
	logic signed [ELEV_BITS-1:0] line_above   [MAX_COLUMNS];
	logic signed [ELEV_BITS-1:0] right_s1;   // also the prefetched centre of the next word
	logic signed [ELEV_BITS-1:0] above_s1;
	logic signed [ELEV_BITS-1:0] down_s1;
	logic signed [ELEV_BITS-1:0] centre_s1;
	logic signed [ELEV_BITS-1:0] left_s1;
	logic signed [ELEV_BITS-1:0] centre_now;
	logic                        fwd_q;

	// single-column rows: the centre is the word just written
	assign centre_now = fwd_q ? down_s1 : right_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			right_s1           <= line_current[pf_addr];
			line_current[col]  <= elevation;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			above_s1         <= line_above[col];
			line_above[col]  <= centre_now;
		end
	end

	logic gx_pos_s1, gy_pos_s1, eof_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			down_s1   <= elevation;
			centre_s1 <= centre_now;
			left_s1   <= centre_s1;
			gx_pos_s1 <= (col != '0) && has_right;
			gy_pos_s1 <= !flush && (row_q >= ROWS_W'(2));
			eof_s1    <= flush && (col_next == eff_cols);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_q <= 1'b0;
		else if (in_acc)
			fwd_q <= (pf_addr == col);
	end

	// ------------------------------------------------------------------ stage 1: operand select
	function automatic logic is_nd(input logic signed [ELEV_BITS-1:0] v,
	                               input logic signed [MARKER_W-1:0] m);
		logic [ND_W-1:0]        ext;
		logic signed [ND_W-1:0] ip;
		logic signed [ND_W-1:0] mk;
		ext = {{(ND_W-ELEV_BITS){v[ELEV_BITS-1]}}, v};
		ip  = $signed(ext) >>> FRAC_BITS;
		// truncate toward zero
		if (v[ELEV_BITS-1] && (v[FRAC_BITS-1:0] != '0))
			ip = ip + ND_W'(1);
		mk = {{(ND_W-MARKER_W){m[MARKER_W-1]}}, m};
		return ip == mk;
	endfunction

	logic                        missing_s1;
	logic signed [ELEV_BITS-1:0] first_a  [2];
	logic signed [ELEV_BITS-1:0] second_a [2];
	logic                        en_a     [2];
	logic [MAG_W-1:0]            mag_a    [2];
	logic                        neg_a    [2];
	logic                        half_a   [2];

	always_comb begin
		logic signed [MAG_W-1:0] d1, d2, dc;
		logic [MAG_W-1:0]        a1, a2, ac;
		logic                    fv, sv, ext_hit;
		missing_s1  = is_nd(centre_s1, marker_q);
		first_a[0]  = left_s1;
		second_a[0] = right_s1;
		en_a[0]     = gx_pos_s1 && !missing_s1;
		first_a[1]  = down_s1;
		second_a[1] = above_s1;
		en_a[1]     = gy_pos_s1 && !missing_s1;
		for (int a = 0; a < 2; a++) begin
			fv = !is_nd(first_a[a], marker_q);
			sv = !is_nd(second_a[a], marker_q);
			d1 = MAG_W'(centre_s1) - MAG_W'(first_a[a]);
			d2 = MAG_W'(second_a[a]) - MAG_W'(centre_s1);
			dc = MAG_W'(second_a[a]) - MAG_W'(first_a[a]);
			a1 = d1[MAG_W-1] ? MAG_W'(-d1) : MAG_W'(d1);
			a2 = d2[MAG_W-1] ? MAG_W'(-d2) : MAG_W'(d2);
			ac = dc[MAG_W-1] ? MAG_W'(-dc) : MAG_W'(dc);
			ext_hit = (d1[MAG_W-1] && !d2[MAG_W-1] && (d2 != '0))
			       || (!d1[MAG_W-1] && (d1 != '0) && d2[MAG_W-1]);
			mag_a[a]  = '0;
			neg_a[a]  = 1'b0;
			half_a[a] = 1'b0;
			if (fv && sv) begin
				if (ext_hit) begin
					if (a1 > a2) begin
						mag_a[a] = a1;
						neg_a[a] = d1[MAG_W-1];
					end else begin
						mag_a[a] = a2;
						neg_a[a] = d2[MAG_W-1];
					end
				end else begin
					mag_a[a]  = ac;
					neg_a[a]  = dc[MAG_W-1];
					half_a[a] = 1'b1;
				end
			end else if (sv) begin
				mag_a[a] = a2;
				neg_a[a] = d2[MAG_W-1];
			end else if (fv) begin
				mag_a[a] = a1;
				neg_a[a] = d1[MAG_W-1];
			end
			if (!en_a[a])
				mag_a[a] = '0;
		end
	end

	// ------------------------------------------------------------------ stage 2: partial products
	logic [MAG_W-1:0]      mag_s2  [2];
	logic                  neg_s2  [2];
	logic                  half_s2 [2];
	logic                  missing_s2, eof_s2;

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int a = 0; a < 2; a++) begin
				mag_s2[a]  <= mag_a[a];
				neg_s2[a]  <= neg_a[a];
				half_s2[a] <= half_a[a];
			end
			missing_s2 <= missing_s1;
			eof_s2     <= eof_s1;
		end
	end

	logic [LO_W+INV_W-1:0] pplo_s3 [2];
	logic [HI_W+INV_W-1:0] pphi_s3 [2];
	logic                  neg_s3  [2];
	logic                  half_s3 [2];
	logic                  missing_s3, eof_s3;

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int a = 0; a < 2; a++) begin
				pplo_s3[a] <= (LO_W+INV_W)'(mag_s2[a][LO_W-1:0]) * (LO_W+INV_W)'(inv_q[a]);
				pphi_s3[a] <= (HI_W+INV_W)'(mag_s2[a][MAG_W-1:LO_W]) * (HI_W+INV_W)'(inv_q[a]);
				neg_s3[a]  <= neg_s2[a];
				half_s3[a] <= half_s2[a];
			end
			missing_s3 <= missing_s2;
			eof_s3     <= eof_s2;
		end
	end

	// ------------------------------------------------------------------ stage 3: product sum
	logic [P_W-1:0] prod_s4 [2];
	logic           neg_s4  [2];
	logic           half_s4 [2];
	logic           missing_s4, eof_s4;

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int a = 0; a < 2; a++) begin
				prod_s4[a] <= (P_W'(pphi_s3[a]) << LO_W) + P_W'(pplo_s3[a]);
				neg_s4[a]  <= neg_s3[a];
				half_s4[a] <= half_s3[a];
			end
			missing_s4 <= missing_s3;
			eof_s4     <= eof_s3;
		end
	end

	// ------------------------------------------------------------------ stage 4: round, saturate
	logic [GRAD_W-1:0] grad_a [2];

	always_comb begin
		logic [P_W-1:0] sh;
		logic           rb;
		logic [Q_W-1:0] q;
		for (int a = 0; a < 2; a++) begin
			// centred difference is halved: one more bit of shift
			if (half_s4[a]) begin
				sh = prod_s4[a] >> (FRAC_BITS + 1);
				rb = prod_s4[a][FRAC_BITS];
			end else begin
				sh = prod_s4[a] >> FRAC_BITS;
				rb = prod_s4[a][FRAC_BITS-1];
			end
			q = Q_W'(sh[P_W-FRAC_BITS-1:0]) + Q_W'(rb);
			if (!neg_s4[a])
				grad_a[a] = (q > Q_W'(GRAD_MAX_POS)) ? GRAD_MAX_POS : q[GRAD_W-1:0];
			else
				grad_a[a] = (q > Q_W'(GRAD_MIN_NEG)) ? GRAD_MIN_NEG : -q[GRAD_W-1:0];
		end
		if (!missing_s4 && grad_a[1] == '0)
			grad_a[1] = GRAD_ONE_LSB;
	end

	logic [GRAD_W-1:0] gx_q, gy_q;
	logic              miss_q, eof_q;

	always_ff @(posedge clk) begin
		if (en4) begin
			gx_q   <= grad_a[0];
			gy_q   <= grad_a[1];
			miss_q <= missing_s4;
			eof_q  <= eof_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			v4_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc)
				v1_q <= produce;
			else if (en1)
				v1_q <= 1'b0;
			if (en1) v2_q        <= v1_q;
			if (en2) v3_q        <= v2_q;
			if (en3) v4_q        <= v3_q;
			if (en4) out_valid_q <= v4_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign gradient_x   = gx_q;
	assign gradient_y   = gy_q;
	assign cell_missing = miss_q;
	assign last_of_run  = 1'b1;
	assign end_of_frame = eof_q;

	// ------------------------------------------------------------------ checks
	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cell_missing |-> gradient_x == '0 && gradient_y == '0)
		else $error("missing cell with nonzero gradient");

	a_gy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cell_missing |-> gradient_y != '0)
		else $error("zero y gradient on a valid cell");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		COLS_W'(col_q) < eff_cols)
		else $error("column counter beyond row length");

	a_frame_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(frame_done_q) |-> $past(restart))
		else $error("frame flag cleared without a geometry write");

endmodule

>>> test/tb_top.sv
// Testbench for dem_gradient_nodata_core: random and directed raster streams checked
// word by word against a behavioral gradient predictor kept inside this module.
// Depends on dgn_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
	import dgn_pkg::*;

	localparam int MAX_COLS     = 4096;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_AT      = 30;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_REPORTS  = 10;

	// index with no register behind it; writes there are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

	// nodata word for the reset marker, integer part only
	localparam logic [31:0] ND_WORD = {MARKER_RESET[23:0], 8'h00};

	localparam logic [31:0] DIRECTED_CELLS [21] = '{
		32'h0000_0000, 32'h0000_0100, 32'h0000_0200,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
		ND_WORD - 32'd255, 32'h0000_03E8, ND_WORD,
		32'h0000_01F4, ND_WORD, ND_WORD + 32'd128,
		32'h0000_0007, 32'h0000_0007, 32'h0000_0007,
		32'h0000_0007, 32'h0000_0007, 32'h0000_0007,
		32'h0000_0007, 32'h0000_0007, 32'h0000_0007
	};

	typedef struct packed {
		logic [GRAD_W-1:0] gx;
		logic [GRAD_W-1:0] gy;
		logic              missing;
		logic              last;
		logic              eof;
	} grad_result_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [31:0]           elevation = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [GRAD_W-1:0]     gradient_x;
	logic [GRAD_W-1:0]     gradient_y;
	logic                  cell_missing;
	logic                  last_of_run;
	logic                  end_of_frame;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	dem_gradient_nodata_core #(
		.MAX_COLUMNS(MAX_COLS),
		.ELEV_BITS(32)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.elevation(elevation),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gradient_x(gradient_x),
		.gradient_y(gradient_y),
		.cell_missing(cell_missing),
		.last_of_run(last_of_run),
		.end_of_frame(end_of_frame),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// gradient predictor state
	logic [COLS_CFG_W-1:0] reg_cols = COLS_RESET;
	logic [ROWS_W-1:0]     reg_rows = ROWS_RESET;
	longint                reg_marker = longint'($signed(MARKER_RESET));
	logic [INV_W-1:0]      reg_inv_x = INV_RESET;
	logic [INV_W-1:0]      reg_inv_y = INV_RESET;
	longint                cur_row_buf [MAX_COLS];
	longint                prev_row_buf [MAX_COLS];
	longint                win [6];
	int unsigned           pred_col = 0;
	int unsigned           pred_row = 0;
	bit                    frame_wrapped = 1'b0;

	logic [31:0]  elev_q [$];
	grad_result_t expected_grads [$];
	grad_result_t want;
	longint       terrain_level = 0;
	int           burst_left = 0;
	int           gap_left = 0;
	int           fail_count = 0;
	int           results_seen = 0;
	int           hold_left = 0;
	int           mode_left = 0;
	rx_mode_t     rx_mode = RX_OPEN;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit is_nodata_cell(input longint v);
		return (v / 256) == reg_marker;
	endfunction

	// Q24.8 difference times Q16.16 reciprocal, rounded half away from zero, saturated
	function automatic logic [GRAD_W-1:0] scale_diff(input longint d, input logic [31:0] inv,
			input int unsigned sh);
		longint     mag;
		logic [65:0] prod;
		logic [65:0] q;
		mag = (d < 0) ? -d : d;
		prod = {32'b0, mag[33:0]} * {34'b0, inv};
		q = (prod >> sh) + ((prod >> (sh - 1)) & 66'd1);
		if (d >= 0)
			return (q > 66'h7FFF_FFFF) ? GRAD_MAX_POS : q[31:0];
		if (q > 66'h8000_0000)
			return GRAD_MIN_NEG;
		return 32'd0 - q[31:0];
	endfunction

	// second minus first is the positive direction
	function automatic logic [GRAD_W-1:0] axis_grad(input longint first, input longint centre,
			input longint second, input logic [31:0] inv);
		bit     first_ok, second_ok, peak;
		longint d1, d2, a1, a2;
		first_ok = !is_nodata_cell(first);
		second_ok = !is_nodata_cell(second);
		d1 = centre - first;
		d2 = second - centre;
		if (first_ok && second_ok) begin
			peak = (d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0);
			if (!peak)
				return scale_diff(second - first, inv, FRAC_BITS + 1);
			a1 = (d1 < 0) ? -d1 : d1;
			a2 = (d2 < 0) ? -d2 : d2;
			return (a1 > a2) ? scale_diff(d1, inv, FRAC_BITS) : scale_diff(d2, inv, FRAC_BITS);
		end
		if (second_ok)
			return scale_diff(d2, inv, FRAC_BITS);
		if (first_ok)
			return scale_diff(d1, inv, FRAC_BITS);
		return '0;
	endfunction

	function automatic void restart_frame();
		pred_col = 0;
		pred_row = 0;
		frame_wrapped = 1'b0;
		foreach (win[i])
			win[i] = 0;
	endfunction

	function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
		case (idx)
			CFG_GRID_COLUMNS: begin
				reg_cols = d[COLS_CFG_W-1:0];
				restart_frame();
			end
			CFG_GRID_ROWS: begin
				reg_rows = d[ROWS_W-1:0];
				restart_frame();
			end
			CFG_NODATA_MARKER: reg_marker = longint'($signed(d));
			CFG_INV_SPACING_X: reg_inv_x = d;
			CFG_INV_SPACING_Y: reg_inv_y = d;
			default: ;
		endcase
	endfunction

	// one accepted elevation word; results trail the input by one row
	function automatic void predict_cell(input logic [31:0] word);
		int unsigned  ncols, nrows, c, r;
		longint       s;
		bit           flush;
		logic [31:0]  gx, gy;
		grad_result_t res;
		ncols = (reg_cols == 0) ? 1 : ((reg_cols > MAX_COLS) ? MAX_COLS : reg_cols);
		nrows = (reg_rows == 0) ? 1 : reg_rows;
		c = pred_col;
		r = pred_row;
		s = longint'($signed(word));
		if (c >= ncols)
			c = ncols - 1;
		if (r >= 1 || frame_wrapped) begin
			flush = (r == 0);
			gx = '0;
			gy = '0;
			win[1] = cur_row_buf[c];
			win[2] = (c + 1 < ncols) ? cur_row_buf[c + 1] : 0;
			win[3] = prev_row_buf[c];
			win[4] = s;
			res.missing = is_nodata_cell(win[1]);
			if (!res.missing) begin
				if (c >= 1 && c + 1 < ncols)
					gx = axis_grad(win[0], win[1], win[2], reg_inv_x);
				if (!flush && r >= 2)
					gy = axis_grad(win[4], win[1], win[3], reg_inv_y);
				if (gy == 0)
					gy = GRAD_ONE_LSB;
			end
			res.gx = gx;
			res.gy = gy;
			res.last = 1'b1;
			res.eof = flush && (c + 1 == ncols);
			expected_grads.push_back(res);
			win[0] = win[1];
		end
		prev_row_buf[c] = cur_row_buf[c];
		cur_row_buf[c] = s;
		c++;
		if (c >= ncols) begin
			c = 0;
			r++;
			if (r >= nrows) begin
				r = 0;
				frame_wrapped = 1'b1;
			end
		end
		pred_col = c;
		pred_row = r & 16'hFFFF;
	endfunction

	// mix of smooth terrain, nodata hits, extremes and raw noise
	function automatic logic [31:0] gen_elev();
		int unsigned pick, off;
		longint      v;
		pick = $urandom_range(0, 99);
		if (pick < 12 && reg_marker >= -8388608 && reg_marker <= 8388607) begin
			off = $urandom_range(0, 255);
			if (reg_marker < 0 || (reg_marker == 0 && $urandom_range(0, 1) == 1))
				v = reg_marker * 256 - off;
			else
				v = reg_marker * 256 + off;
		end else if (pick < 26) begin
			v = longint'($urandom);
		end else if (pick < 32) begin
			case ($urandom_range(0, 3))
				0: v = 32'h7FFF_FFFF;
				1: v = 32'h8000_0000;
				2: v = 0;
				default: v = 32'hFFFF_FFFF;
			endcase
		end else begin
			if ($urandom_range(0, 4) != 0)
				terrain_level += longint'($urandom_range(0, 2048)) - 1024;
			if (terrain_level > 2**30 || terrain_level < -(2**30))
				terrain_level = 0;
			v = terrain_level;
		end
		return v[31:0];
	endfunction

	function automatic logic [31:0] rand_inv();
		return ($urandom_range(0, 3) == 0) ? $urandom
			: $urandom_range(32'h0010_0000, 32'h0000_1000);
	endfunction

	function automatic logic [31:0] rand_marker();
		return 32'($signed($urandom_range(0, 4000)) - 2000);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		apply_cfg(idx, d);
		cfg_valid <= 1'b0;
	endtask

	// block empty: nothing queued, nothing owed, pipeline given time to settle
	task automatic wait_idle();
		do @(negedge clk); while (elev_q.size() != 0 || in_valid || expected_grads.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic [31:0] cols, input logic [31:0] rows,
			input logic [31:0] marker, input logic [31:0] inv_x, input logic [31:0] inv_y,
			input int nwords);
		wait_idle();
		write_reg(CFG_NODATA_MARKER, marker);
		write_reg(CFG_INV_SPACING_X, inv_x);
		write_reg(CFG_INV_SPACING_Y, inv_y);
		write_reg(CFG_GRID_COLUMNS, cols);
		write_reg(CFG_GRID_ROWS, rows);
		@(negedge clk);
		repeat (nwords)
			elev_q.push_back(gen_elev());
	endtask

	// sender: bursts of words with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			elevation <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready)
				predict_cell(elevation);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (elev_q.size() > 0) begin
					in_valid <= 1'b1;
					elevation <= elev_q.pop_front();
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 32);
						if ($urandom_range(0, 2) == 0)
							gap_left = 0;
						else if ($urandom_range(0, 7) == 0)
							gap_left = $urandom_range(8, 20);
						else
							gap_left = $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern changes at random intervals, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
			mode_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (results_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
				if (expected_grads.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected word: gx=%h gy=%h miss=%b last=%b eof=%b",
							gradient_x, gradient_y, cell_missing, last_of_run, end_of_frame);
				end else begin
					want = expected_grads.pop_front();
					if (gradient_x !== want.gx || gradient_y !== want.gy ||
							cell_missing !== want.missing || last_of_run !== want.last ||
							end_of_frame !== want.eof) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("word %0d: expected gx=%h gy=%h miss=%b last=%b eof=%b",
								results_seen, want.gx, want.gy, want.missing, want.last,
								want.eof);
							$display("  got gx=%h gy=%h miss=%b last=%b eof=%b",
								gradient_x, gradient_y, cell_missing, last_of_run,
								end_of_frame);
						end
					end
				end
			end
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
					RX_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
					default:   out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(CFG_IDX_SPARE, $urandom);

		// hand-picked 3-column grid: ramps, full-scale swings, nodata around
		// and in the centre, a near-miss of the marker, then a flat patch
		run_phase(32'd3, 32'd4, MARKER_RESET, INV_RESET, INV_RESET, 0);
		foreach (DIRECTED_CELLS[i])
			elev_q.push_back(DIRECTED_CELLS[i]);

		run_phase(32'd5, 32'd4, rand_marker(), rand_inv(), rand_inv(), 40);
		run_phase(32'd1, 32'd0, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 8);
		run_phase(32'd2, 32'd65535, 32'h7FFF_FFFF, INV_RESET, 32'h0000_8000, 10);
		run_phase(32'd0, 32'd3, 32'd0, rand_inv(), rand_inv(), 8);
		run_phase(32'd7, 32'd2, rand_marker(), 32'hFFFF_FFFF, 32'd0, 14);
		// oversized column count; the short run stays inside the first row
		run_phase(32'd8191, 32'd1, MARKER_RESET, rand_inv(), rand_inv(), 4);
		run_phase(32'd4096, 32'd65535, rand_marker(), $urandom, $urandom, 4);
		run_phase(32'd6, 32'd5, rand_marker(), rand_inv(), rand_inv(), 14);

		wait_idle();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
